// ===== sv/skh_pkg.sv =====
package skh_pkg;

   // field widths that the item formats fix
   localparam int BIN_BITS   = 16;
   localparam int COUNT_BITS = 16;
   localparam int TALLY_BITS = 17;
   localparam int TOTAL_BITS = 48;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // request modes
   localparam logic [1:0] MODE_RECORD     = 2'd0;
   localparam logic [1:0] MODE_QUERY_KEY  = 2'd1;
   localparam logic [1:0] MODE_QUERY_BIN  = 2'd2;
   localparam logic [1:0] MODE_READ_TOTAL = 2'd3;

   typedef struct packed {
      logic [1:0]          mode;
      logic [15:0]         key;
      logic [BIN_BITS-1:0] bin_count;
   } req_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] slot_count;
      logic [TALLY_BITS-1:0] keys_in_bin;
      logic [TOTAL_BITS-1:0] total_records;
      logic [TALLY_BITS-1:0] distinct_keys;
      logic [COUNT_BITS-1:0] max_count;
      logic [TOTAL_BITS-1:0] overflow_hits;
   } rsp_type;

endpackage

// ===== sv/skh_ram.sv =====
module skh_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/skh_sweep.sv =====
module skh_sweep #(
   parameter int ADDR_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   output logic                 active,
   output logic [ADDR_BITS-1:0] addr
);

   logic                 active_ff, active_in;
   logic [ADDR_BITS-1:0] addr_ff, addr_in;

   // walk every address once after reset, then stop
   always_comb begin
      active_in = active_ff;
      addr_in   = addr_ff;
      if (active_ff) begin
         addr_in = addr_ff + ADDR_BITS'(1);
         if (addr_ff == '1) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b1;
         addr_ff   <= '0;
      end else begin
         active_ff <= active_in;
         addr_ff   <= addr_in;
      end
   end

   assign active = active_ff;
   assign addr   = addr_ff;

endmodule

// ===== sv/saturating_key_histogram.sv =====
// Saturating key histogram: per-key 16-bit counters that stick at 65535,
// plus a count-of-counts store and running totals.
// Request channel (req_valid/req_ready/req_data): one item per transfer,
// mode 0 records a key, 1 queries a key's count, 2 queries how many keys
// hold bin_count, 3 reads the totals. Result channel (rsp_valid/rsp_ready/
// rsp_data): exactly one result per request, totals always included.
// A record steps through READ, BIN_DEC, BIN_INC and DONE (READ and DONE
// if the key is already saturated); every other mode through READ and
// DONE. Items are handled one at a time; the next request is taken the
// cycle after the result is loaded into the output register. A record
// does a read-modify-write of the key store followed by two accesses to
// the single-port-write count-of-counts store.
// Reset (synchronous, active high) zeroes the totals and starts a clearing
// pass over both stores, walking every address of the larger one once,
// during which req_ready stays low.
// A stalled receiver holds the result in the output register; one further
// item may be worked on meanwhile and waits in its final step until the
// output register frees up.
module saturating_key_histogram
   import skh_pkg::*;
#(
   parameter int KEY_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int KEY_SLOTS  = 1 << KEY_BITS;
   localparam int BIN_SLOTS  = 1 << BIN_BITS;
   localparam int SWEEP_BITS = (KEY_BITS > BIN_BITS) ? KEY_BITS : BIN_BITS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_BIN_DEC,
      ST_BIN_INC,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;

   logic [1:0]            mode_ff, mode_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [BIN_BITS-1:0]   bin_ff, bin_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [COUNT_BITS-1:0] slot_ff, slot_in;
   logic [TALLY_BITS-1:0] kbin_ff, kbin_in;
   logic [TOTAL_BITS-1:0] total_ff, total_in;
   logic [TALLY_BITS-1:0] distinct_ff, distinct_in;
   logic [COUNT_BITS-1:0] highest_ff, highest_in;
   logic [TOTAL_BITS-1:0] overflow_ff, overflow_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  sweep_active;
   logic [SWEEP_BITS-1:0] sweep_addr;

   logic                  key_wr_en;
   logic [KEY_BITS-1:0]   key_wr_addr;
   logic [COUNT_BITS-1:0] key_wr_data;
   logic [KEY_BITS-1:0]   key_rd_addr;
   logic [COUNT_BITS-1:0] key_rd_data;

   logic                  bin_wr_en;
   logic [BIN_BITS-1:0]   bin_wr_addr;
   logic [TALLY_BITS-1:0] bin_wr_data;
   logic [BIN_BITS-1:0]   bin_rd_addr;
   logic [TALLY_BITS-1:0] bin_rd_data;

   logic                  req_xfer;
   logic [COUNT_BITS-1:0] count_next;

   // clearing pass after reset
   skh_sweep #(
      .ADDR_BITS(SWEEP_BITS)
   ) u_sweep (
      .clock (clock),
      .reset (reset),
      .active(sweep_active),
      .addr  (sweep_addr)
   );

   // per-key counters
   skh_ram #(
      .WIDTH(COUNT_BITS),
      .DEPTH(KEY_SLOTS)
   ) u_key_ram (
      .clock  (clock),
      .wr_en  (key_wr_en),
      .wr_addr(key_wr_addr),
      .wr_data(key_wr_data),
      .rd_en  (!sweep_active),
      .rd_addr(key_rd_addr),
      .rd_data(key_rd_data)
   );

   // count-of-counts
   skh_ram #(
      .WIDTH(TALLY_BITS),
      .DEPTH(BIN_SLOTS)
   ) u_bin_ram (
      .clock  (clock),
      .wr_en  (bin_wr_en),
      .wr_addr(bin_wr_addr),
      .wr_data(bin_wr_data),
      .rd_en  (!sweep_active),
      .rd_addr(bin_rd_addr),
      .rd_data(bin_rd_data)
   );

   assign req_ready  = (state_ff == ST_IDLE) && !sweep_active;
   assign req_xfer   = req_valid && req_ready;
   assign count_next = count_ff + COUNT_BITS'(1);

   // key store port control
   always_comb begin
      key_rd_addr = KEY_BITS'(req_data.key);
      key_wr_en   = 1'b0;
      key_wr_addr = key_ff;
      key_wr_data = count_next;
      if (sweep_active) begin
         key_wr_en   = 1'b1;
         key_wr_addr = KEY_BITS'(sweep_addr);
         key_wr_data = '0;
      end else if (state_ff == ST_BIN_DEC) begin
         key_wr_en = 1'b1;
      end
   end

   // count-of-counts port control: read old bin, drop it, bump the new bin
   always_comb begin
      bin_rd_addr = req_data.bin_count;
      bin_wr_en   = 1'b0;
      bin_wr_addr = count_ff;
      bin_wr_data = bin_rd_data - TALLY_BITS'(1);
      case (state_ff)
         ST_READ:    bin_rd_addr = key_rd_data;
         ST_BIN_DEC: bin_rd_addr = count_next;
         default:    bin_rd_addr = req_data.bin_count;
      endcase
      if (sweep_active) begin
         bin_wr_en   = 1'b1;
         bin_wr_addr = BIN_BITS'(sweep_addr);
         bin_wr_data = '0;
      end else if (state_ff == ST_BIN_DEC) begin
         bin_wr_en = (count_ff != '0);
      end else if (state_ff == ST_BIN_INC) begin
         bin_wr_en   = 1'b1;
         bin_wr_addr = count_next;
         bin_wr_data = bin_rd_data + TALLY_BITS'(1);
      end
   end

   // sequencer and totals
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      key_in       = key_ff;
      bin_in       = bin_ff;
      count_in     = count_ff;
      slot_in      = slot_ff;
      kbin_in      = kbin_ff;
      total_in     = total_ff;
      distinct_in  = distinct_ff;
      highest_in   = highest_ff;
      overflow_in  = overflow_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               mode_in  = req_data.mode;
               key_in   = KEY_BITS'(req_data.key);
               bin_in   = req_data.bin_count;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            count_in = key_rd_data;
            slot_in  = '0;
            kbin_in  = '0;
            state_in = ST_DONE;
            case (mode_ff)
               MODE_RECORD: begin
                  total_in = total_ff + TOTAL_BITS'(1);
                  if (key_rd_data == COUNT_MAX) begin
                     overflow_in = overflow_ff + TOTAL_BITS'(1);
                     slot_in     = COUNT_MAX;
                  end else begin
                     slot_in  = key_rd_data + COUNT_BITS'(1);
                     state_in = ST_BIN_DEC;
                     if (key_rd_data == '0) begin
                        distinct_in = distinct_ff + TALLY_BITS'(1);
                     end
                     if (key_rd_data + COUNT_BITS'(1) > highest_ff) begin
                        highest_in = key_rd_data + COUNT_BITS'(1);
                     end
                  end
               end
               MODE_QUERY_KEY: slot_in = key_rd_data;
               MODE_QUERY_BIN: begin
                  if (bin_ff != '0) begin
                     kbin_in = bin_rd_data;
                  end
               end
               default: slot_in = '0;
            endcase
         end
         ST_BIN_DEC: state_in = ST_BIN_INC;
         ST_BIN_INC: state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in         = 1'b1;
               rsp_in.slot_count    = slot_ff;
               rsp_in.keys_in_bin   = kbin_ff;
               rsp_in.total_records = total_ff;
               rsp_in.distinct_keys = distinct_ff;
               rsp_in.max_count     = highest_ff;
               rsp_in.overflow_hits = overflow_ff;
               state_in             = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         distinct_ff  <= '0;
         highest_ff   <= '0;
         overflow_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         distinct_ff  <= distinct_in;
         highest_ff   <= highest_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff  <= mode_in;
      key_ff   <= key_in;
      bin_ff   <= bin_in;
      count_ff <= count_in;
      slot_ff  <= slot_in;
      kbin_ff  <= kbin_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // no transfer while the stores are being cleared
   a_no_req_in_sweep: assert property (@(posedge clock) disable iff (reset)
      sweep_active |-> !req_ready)
      else $error("request taken during clearing pass");

   // the highest count already covers the count being written back
   a_highest_covers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BIN_DEC) |-> (highest_ff > count_ff))
      else $error("highest count below new key count");

   // a finished item waits while the output register is full and stalled
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_valid_ff && !rsp_ready) |=> (state_ff == ST_DONE))
      else $error("result dropped under stall");

   // a record never leaves the count-of-counts sequence early
   a_bin_sequence: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BIN_DEC) |=> (state_ff == ST_BIN_INC))
      else $error("count-of-counts update cut short");

endmodule
